// ===== hdl/ajs_pkg.sv =====
// Shared constants, control types and the quarter-octave gain table for joint-stereo reconstruction.
package ajs_pkg;

    localparam int COEF_WIDTH_DEF = 32;
    localparam int GAIN_W         = 31;
    localparam int SHIFT_W        = 9;
    localparam int SF_W           = 9;
    localparam int EXP_W          = 10;

    localparam logic [3:0] CB_IS_OUT_PHASE = 4'd14;
    localparam logic [3:0] CB_IS_IN_PHASE  = 4'd15;

    localparam logic [1:0] MS_MODE_OFF     = 2'd0;
    localparam logic [1:0] MS_MODE_BAND    = 2'd1;
    localparam logic [1:0] MS_MODE_ALL     = 2'd2;
    localparam logic [1:0] MS_MODE_NO_FLIP = 2'd3;

    localparam logic signed [SF_W-1:0] IS_POS_MAX = 9'sd128;
    localparam logic signed [SF_W-1:0] IS_POS_MIN = -9'sd128;

    // Scale request that travels alongside the coefficient pair.
    typedef struct packed {
        logic                      scl;    // right output comes from the gain path
        logic                      neg;    // invert the sign of the scaled result
        logic [1:0]                g_idx;  // fractional quarter-octave step
        logic signed [SHIFT_W-1:0] shift;  // right shift after the Q1.30 product, left when negative
    } t_ajs_ctl;

    // 2^(idx/4) in Q1.30, rounded to nearest.
    function automatic logic [GAIN_W-1:0] gain_q30(input logic [1:0] idx);
        logic [GAIN_W-1:0] g;
        case (idx)
            2'd0:    g = 31'd1073741824;
            2'd1:    g = 31'd1276901417;
            2'd2:    g = 31'd1518500250;
            default: g = 31'd1805811301;
        endcase
        return g;
    endfunction

endpackage

// ===== hdl/ajs_ms_decode.sv =====
// Mid/side sum and difference with saturation, and decode of the gain request.
module ajs_ms_decode #(
    parameter int COEF_WIDTH = ajs_pkg::COEF_WIDTH_DEF
) (
    input  logic signed [COEF_WIDTH-1:0]    i_left_coef,
    input  logic signed [COEF_WIDTH-1:0]    i_right_coef,
    input  logic [1:0]                      i_ms_mode,
    input  logic                            i_ms_band_flag,
    input  logic                            i_pns_left,
    input  logic                            i_pns_right,
    input  logic [3:0]                      i_right_codebook,
    input  logic signed [ajs_pkg::SF_W-1:0] i_left_scalefactor,
    input  logic signed [ajs_pkg::SF_W-1:0] i_right_scalefactor,
    output logic signed [COEF_WIDTH-1:0]    o_left,
    output logic signed [COEF_WIDTH-1:0]    o_right,
    output ajs_pkg::t_ajs_ctl               o_ctl
);
    import ajs_pkg::*;

    localparam logic [COEF_WIDTH-1:0] C_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic [COEF_WIDTH-1:0] C_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    logic signed [COEF_WIDTH:0]  sum;
    logic signed [COEF_WIDTH:0]  dif;
    logic [COEF_WIDTH-1:0]       sum_sat;
    logic [COEF_WIDTH-1:0]       dif_sat;
    logic                        ms_on;
    logic                        ms_sd;
    logic                        ms_pns;
    logic                        is_on;
    logic                        flip_ms;
    logic signed [SF_W-1:0]      pos;
    logic signed [EXP_W-1:0]     expo;
    logic signed [7:0]           q;

    always_comb begin
        sum = {i_left_coef[COEF_WIDTH-1], i_left_coef} + {i_right_coef[COEF_WIDTH-1], i_right_coef};
        dif = {i_left_coef[COEF_WIDTH-1], i_left_coef} - {i_right_coef[COEF_WIDTH-1], i_right_coef};
        sum_sat = (sum[COEF_WIDTH] != sum[COEF_WIDTH-1]) ?
                  (sum[COEF_WIDTH] ? C_MIN : C_MAX) : sum[COEF_WIDTH-1:0];
        dif_sat = (dif[COEF_WIDTH] != dif[COEF_WIDTH-1]) ?
                  (dif[COEF_WIDTH] ? C_MIN : C_MAX) : dif[COEF_WIDTH-1:0];

        ms_on   = (i_ms_mode == MS_MODE_BAND) ? i_ms_band_flag : (i_ms_mode != MS_MODE_OFF);
        ms_sd   = ms_on && (i_pns_left == i_pns_right) && !i_pns_left;
        ms_pns  = ms_on && (i_pns_left == i_pns_right) && i_pns_left;
        is_on   = (i_right_codebook == CB_IS_OUT_PHASE) || (i_right_codebook == CB_IS_IN_PHASE);
        flip_ms = (i_ms_mode == MS_MODE_ALL) || ((i_ms_mode == MS_MODE_BAND) && i_ms_band_flag);

        if (i_right_scalefactor > IS_POS_MAX) begin
            pos = IS_POS_MAX;
        end else if (i_right_scalefactor < IS_POS_MIN) begin
            pos = IS_POS_MIN;
        end else begin
            pos = i_right_scalefactor;
        end

        // Intensity gain is 0.5^(pos/4), noise gain is 2^((sfR - sfL)/4).
        if (is_on) begin
            expo = 10'sd0 - {pos[SF_W-1], pos};
        end else begin
            expo = {i_right_scalefactor[SF_W-1], i_right_scalefactor}
                 - {i_left_scalefactor[SF_W-1], i_left_scalefactor};
        end
        q = expo[EXP_W-1:2];

        o_left        = ms_sd ? sum_sat : i_left_coef;
        o_right       = ms_sd ? dif_sat : i_right_coef;
        o_ctl.scl     = is_on || ms_pns;
        o_ctl.neg     = is_on && ((i_right_codebook == CB_IS_OUT_PHASE) ^ flip_ms);
        o_ctl.g_idx   = expo[1:0];
        o_ctl.shift   = 9'sd30 - {q[7], q};
    end

endmodule

// ===== hdl/ajs_gain_mul.sv =====
// Magnitude, split gain multiply, partial product sum and rounding add, four register stages.
module ajs_gain_mul #(
    parameter int COEF_WIDTH = ajs_pkg::COEF_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic [3:0]                                i_en,
    input  logic signed [COEF_WIDTH-1:0]              i_left,
    input  logic signed [COEF_WIDTH-1:0]              i_right,
    input  ajs_pkg::t_ajs_ctl                         i_ctl,
    output logic [COEF_WIDTH+ajs_pkg::GAIN_W:0]       o_rnd,
    output logic signed [COEF_WIDTH-1:0]              o_left,
    output logic signed [COEF_WIDTH-1:0]              o_right,
    output ajs_pkg::t_ajs_ctl                         o_ctl
);
    import ajs_pkg::*;

    localparam int H  = COEF_WIDTH / 2;
    localparam int PW = COEF_WIDTH + GAIN_W;
    localparam logic signed [SHIFT_W-1:0] PW_S = SHIFT_W'(PW);

    logic [COEF_WIDTH-1:0]          r_s2_mag;
    logic signed [COEF_WIDTH-1:0]   r_s2_left,  r_s3_left,  r_s4_left,  r_s5_left;
    logic signed [COEF_WIDTH-1:0]   r_s2_right, r_s3_right, r_s4_right, r_s5_right;
    t_ajs_ctl                       r_s2_ctl,   r_s3_ctl,   r_s4_ctl,   r_s5_ctl;
    logic [H+GAIN_W-1:0]            r_s3_plo;
    logic [COEF_WIDTH-H+GAIN_W-1:0] r_s3_phi;
    logic [PW-1:0]                  r_s4_prod;
    logic [PW:0]                    r_s5_rnd;
    logic [COEF_WIDTH-1:0]          n_mag;
    t_ajs_ctl                       n_ctl;
    logic [GAIN_W-1:0]              n_gain;
    logic [SHIFT_W-1:0]             n_rbit;
    logic [PW:0]                    n_add;

    always_comb begin
        n_mag     = i_left[COEF_WIDTH-1] ? (COEF_WIDTH'(0) - i_left) : i_left;
        // The sign of the input folds into the sign request, the multiply sees a magnitude.
        n_ctl     = i_ctl;
        n_ctl.neg = i_ctl.neg ^ i_left[COEF_WIDTH-1];
        n_gain    = gain_q30(r_s2_ctl.g_idx);
        n_rbit    = SHIFT_W'(r_s4_ctl.shift - 9'sd1);
        // Half an output LSB, only when the result is shifted right within the product.
        if ((r_s4_ctl.shift > 9'sd0) && (r_s4_ctl.shift <= PW_S)) begin
            n_add = (PW+1)'(1) << n_rbit;
        end else begin
            n_add = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s2_mag     <= n_mag;
            r_s2_left    <= i_left;
            r_s2_right   <= i_right;
            r_s2_ctl     <= n_ctl;
        end
        if (i_en[1]) begin
            r_s3_plo   <= r_s2_mag[H-1:0] * n_gain;
            r_s3_phi   <= r_s2_mag[COEF_WIDTH-1:H] * n_gain;
            r_s3_left  <= r_s2_left;
            r_s3_right <= r_s2_right;
            r_s3_ctl   <= r_s2_ctl;
        end
        if (i_en[2]) begin
            r_s4_prod  <= {r_s3_phi, {H{1'b0}}} + PW'(r_s3_plo);
            r_s4_left  <= r_s3_left;
            r_s4_right <= r_s3_right;
            r_s4_ctl   <= r_s3_ctl;
        end
        if (i_en[3]) begin
            r_s5_rnd   <= {1'b0, r_s4_prod} + n_add;
            r_s5_left  <= r_s4_left;
            r_s5_right <= r_s4_right;
            r_s5_ctl   <= r_s4_ctl;
        end
    end

    assign o_rnd   = r_s5_rnd;
    assign o_left  = r_s5_left;
    assign o_right = r_s5_right;
    assign o_ctl   = r_s5_ctl;

endmodule

// ===== hdl/ajs_shift_sat.sv =====
// Power-of-two shift with saturation, then sign and final result selection, two register stages.
module ajs_shift_sat #(
    parameter int COEF_WIDTH = ajs_pkg::COEF_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic [1:0]                          i_en,
    input  logic [COEF_WIDTH+ajs_pkg::GAIN_W:0] i_rnd,
    input  logic signed [COEF_WIDTH-1:0]        i_left,
    input  logic signed [COEF_WIDTH-1:0]        i_right,
    input  ajs_pkg::t_ajs_ctl                   i_ctl,
    output logic signed [COEF_WIDTH-1:0]        o_left_out,
    output logic signed [COEF_WIDTH-1:0]        o_right_out
);
    import ajs_pkg::*;

    localparam int PW = COEF_WIDTH + GAIN_W;
    localparam logic signed [SHIFT_W-1:0] PW_S = SHIFT_W'(PW);
    localparam logic [SHIFT_W-1:0]        W_U  = SHIFT_W'(COEF_WIDTH);

    logic [COEF_WIDTH-1:0]        r_s6_mag;
    logic                         r_s6_neg;
    logic                         r_s6_scl;
    logic signed [COEF_WIDTH-1:0] r_s6_left;
    logic signed [COEF_WIDTH-1:0] r_s6_right;
    logic signed [COEF_WIDTH-1:0] r_left_out;
    logic signed [COEF_WIDTH-1:0] r_right_out;
    logic [COEF_WIDTH-1:0]        n_limit;
    logic [SHIFT_W-1:0]           n_k;
    logic [PW:0]                  n_shr;
    logic [PW:0]                  n_shl;
    logic [COEF_WIDTH-1:0]        n_mag;

    always_comb begin
        n_limit = i_ctl.neg ? {1'b1, {(COEF_WIDTH-1){1'b0}}} : {1'b0, {(COEF_WIDTH-1){1'b1}}};
        n_k     = SHIFT_W'(-i_ctl.shift);
        n_shr   = i_rnd >> SHIFT_W'(i_ctl.shift);
        n_shl   = i_rnd << n_k;
        if (i_ctl.shift > 9'sd0) begin
            if (i_ctl.shift > PW_S) begin
                n_mag = '0;
            end else if (n_shr > (PW+1)'(n_limit)) begin
                n_mag = n_limit;
            end else begin
                n_mag = n_shr[COEF_WIDTH-1:0];
            end
        end else begin
            // Left shift: anything reaching 2^COEF_WIDTH is clipped before the limit test.
            if (i_rnd == '0) begin
                n_mag = '0;
            end else if (n_k > W_U) begin
                n_mag = n_limit;
            end else if ((i_rnd >> (W_U - n_k)) != '0) begin
                n_mag = n_limit;
            end else if (n_shl[COEF_WIDTH-1:0] > n_limit) begin
                n_mag = n_limit;
            end else begin
                n_mag = n_shl[COEF_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s6_mag   <= n_mag;
            r_s6_neg   <= i_ctl.neg;
            r_s6_scl   <= i_ctl.scl;
            r_s6_left  <= i_left;
            r_s6_right <= i_right;
        end
        if (i_en[1]) begin
            r_left_out <= r_s6_left;
            if (!r_s6_scl) begin
                r_right_out <= r_s6_right;
            end else if (r_s6_neg) begin
                r_right_out <= COEF_WIDTH'(0) - r_s6_mag;
            end else begin
                r_right_out <= r_s6_mag;
            end
        end
    end

    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

// ===== hdl/aac_joint_stereo_reconstruct.sv =====
// Top level of the joint-stereo reconstruction pipeline: stream ports, valid chain and stage 1.
//
// One input beat carries a left/right spectral coefficient pair with the attributes of its
// scalefactor band; one output beat carries the reconstructed pair. Mid/side gives sum and
// difference, or a scaled left for noise-substituted bands, and intensity codebooks then
// rebuild right from the new left with a quarter-octave gain. All results saturate.
// The slave channel takes beats on i_s_axis_*, the master channel delivers them on
// o_m_axis_*; a beat moves when tvalid and tready are both high at a rising edge.
// An accepted beat runs through stage 1, the gain multiply stages and the shift stages.
// Throughput is one beat per cycle unless the receiver stalls; each of the seven stages
// has its own valid bit and loads whenever it is empty or the stage after it moves, so
// gaps in the stream are squeezed out and new beats are taken while a finished result
// waits at the output. The deepest logic sits in the variable shift and saturation stage
// and the split gain multiply, each in a stage of its own.
// When the receiver holds i_m_axis_tready low, full stages with no gap after them freeze;
// o_s_axis_tready falls only once every stage holds a beat; nothing is dropped or repeated.
// The synchronous active-low reset empties every stage; no beats are delivered until new
// ones arrive. There is no configuration and no state carried between beats.
module aac_joint_stereo_reconstruct #(
    parameter int COEF_WIDTH = ajs_pkg::COEF_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_s_axis_tvalid,
    output logic                                          o_s_axis_tready,
    // From bit 0: left_coef, right_coef, ms_mode, ms_band_flag, pns_left, pns_right,
    // right_codebook, left_scalefactor, right_scalefactor, zero padding.
    input  logic [((2*COEF_WIDTH+27+7)/8)*8-1:0]          i_s_axis_tdata,
    output logic                                          o_m_axis_tvalid,
    input  logic                                          i_m_axis_tready,
    // From bit 0: left_out, right_out, zero padding.
    output logic [((2*COEF_WIDTH+7)/8)*8-1:0]             o_m_axis_tdata
);
    import ajs_pkg::*;

    localparam int OUT_TW  = ((2*COEF_WIDTH+7)/8)*8;
    localparam int OFS_R   = COEF_WIDTH;
    localparam int OFS_MM  = 2*COEF_WIDTH;
    localparam int OFS_FL  = OFS_MM + 2;
    localparam int OFS_PL  = OFS_FL + 1;
    localparam int OFS_PR  = OFS_PL + 1;
    localparam int OFS_CB  = OFS_PR + 1;
    localparam int OFS_SFL = OFS_CB + 4;
    localparam int OFS_SFR = OFS_SFL + SF_W;
    localparam int NSTG    = 7;

    logic [NSTG-1:0]              r_vld;
    logic [NSTG-1:0]              stg_en;
    logic signed [COEF_WIDTH-1:0] dec_left;
    logic signed [COEF_WIDTH-1:0] dec_right;
    t_ajs_ctl                     dec_ctl;
    logic signed [COEF_WIDTH-1:0] r_s1_left;
    logic signed [COEF_WIDTH-1:0] r_s1_right;
    t_ajs_ctl                     r_s1_ctl;
    logic [COEF_WIDTH+GAIN_W:0]   mul_rnd;
    logic signed [COEF_WIDTH-1:0] mul_left;
    logic signed [COEF_WIDTH-1:0] mul_right;
    t_ajs_ctl                     mul_ctl;
    logic signed [COEF_WIDTH-1:0] res_left;
    logic signed [COEF_WIDTH-1:0] res_right;

    // A stage loads when it is empty or its successor is loading; the last one when the
    // receiver takes the beat.
    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG-2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    ajs_ms_decode #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_decode (
        .i_left_coef         (i_s_axis_tdata[COEF_WIDTH-1:0]),
        .i_right_coef        (i_s_axis_tdata[OFS_R +: COEF_WIDTH]),
        .i_ms_mode           (i_s_axis_tdata[OFS_MM +: 2]),
        .i_ms_band_flag      (i_s_axis_tdata[OFS_FL]),
        .i_pns_left          (i_s_axis_tdata[OFS_PL]),
        .i_pns_right         (i_s_axis_tdata[OFS_PR]),
        .i_right_codebook    (i_s_axis_tdata[OFS_CB +: 4]),
        .i_left_scalefactor  (i_s_axis_tdata[OFS_SFL +: SF_W]),
        .i_right_scalefactor (i_s_axis_tdata[OFS_SFR +: SF_W]),
        .o_left              (dec_left),
        .o_right             (dec_right),
        .o_ctl               (dec_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s1_left  <= dec_left;
            r_s1_right <= dec_right;
            r_s1_ctl   <= dec_ctl;
        end
    end

    ajs_gain_mul #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_gain_mul (
        .i_clk   (i_clk),
        .i_en    (stg_en[4:1]),
        .i_left  (r_s1_left),
        .i_right (r_s1_right),
        .i_ctl   (r_s1_ctl),
        .o_rnd   (mul_rnd),
        .o_left  (mul_left),
        .o_right (mul_right),
        .o_ctl   (mul_ctl)
    );

    ajs_shift_sat #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_shift_sat (
        .i_clk       (i_clk),
        .i_en        (stg_en[6:5]),
        .i_rnd       (mul_rnd),
        .i_left      (mul_left),
        .i_right     (mul_right),
        .i_ctl       (mul_ctl),
        .o_left_out  (res_left),
        .o_right_out (res_right)
    );

    assign o_s_axis_tready = stg_en[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = OUT_TW'({res_right, res_left});

endmodule

// ===== tb/aac_joint_stereo_reconstruct_tb.sv =====
// Self-checking testbench for the joint-stereo reconstruction stream block.
module aac_joint_stereo_reconstruct_tb;
    import ajs_pkg::*;

    localparam int CW     = 32;
    localparam int IN_W   = ((2*CW+27+7)/8)*8;
    localparam int OUT_W  = ((2*CW+7)/8)*8;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    // Codebooks that take no part in intensity stereo.
    localparam logic [3:0] CB_ZERO  = 4'd0;
    localparam logic [3:0] CB_NOISE = 4'd13;

    // 2^(r/4) in Q1.30 for the fractional part of a quarter-octave exponent.
    localparam longint unsigned ROOT2_Q30 [4] = '{
        64'd1073741824, 64'd1276901417, 64'd1518500250, 64'd1805811301
    };

    typedef struct {
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] right;
        logic [1:0]           mode;
        logic                 band_flag;
        logic                 pns_l;
        logic                 pns_r;
        logic [3:0]           cb;
        logic signed [8:0]    sf_l;
        logic signed [8:0]    sf_r;
    } coef_beat_t;

    typedef struct packed {
        logic [CW-1:0] left_out;
        logic [CW-1:0] right_out;
    } stereo_pair_t;

    typedef struct {
        coef_beat_t   beat;
        bit           typed;
        stereo_pair_t want;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [IN_W-1:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;

    stereo_pair_t pending_pairs [$];
    stim_row_t    directed_rows [$];
    int fail_count    = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 6;
    int snk_stall_pct = 70;

    aac_joint_stereo_reconstruct #(.COEF_WIDTH(CW)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Clamp a wide intermediate to the signed coefficient range.
    function automatic logic [CW-1:0] clip_coef(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[CW-1:0];
    endfunction

    // x * 2^(e/4), magnitude rounded half away from zero and saturated, sign applied last.
    // The negative limit is one larger than the positive one.
    function automatic logic [CW-1:0] quarter_gain(input logic signed [CW-1:0] x, input int e,
                                                  input bit flip);
        bit               neg;
        longint unsigned  mag;
        longint unsigned  limit;
        longint unsigned  res;
        logic [127:0]     acc;
        int               eb;
        int               q;
        int               s;
        neg   = x[CW-1] ^ flip;
        mag   = x[CW-1] ? longint'(-longint'(x)) : longint'(x);
        limit = (64'd1 << (CW-1)) - (neg ? 64'd0 : 64'd1);
        eb    = e + 512;
        q     = (eb >> 2) - 128;
        s     = 30 - q;
        acc   = 128'(mag) * 128'(ROOT2_Q30[eb & 3]);
        if (s > 0) begin
            if (s >= 128) begin
                res = 0;
            end else begin
                acc = (acc + (128'd1 << (s - 1))) >> s;
                res = (acc > 128'(limit)) ? limit : acc[63:0];
            end
        end else begin
            // Left shift: saturate as soon as any set bit would leave the range.
            if (acc == 0) res = 0;
            else if (-s >= 64 || acc[127:64] != 0) res = limit;
            else if (acc[63:0] > (limit >> (-s))) res = limit;
            else res = acc[63:0] << (-s);
        end
        return neg ? 32'(-res) : 32'(res);
    endfunction

    // Expected output pair for one input beat: mid/side first, then intensity.
    function automatic stereo_pair_t rebuild_pair(input coef_beat_t b);
        logic signed [CW-1:0] lv;
        logic signed [CW-1:0] rv;
        bit                   ms;
        bit                   flip;
        int                   pos;
        stereo_pair_t         p;
        lv = b.left;
        rv = b.right;
        ms = (b.mode == MS_MODE_BAND) ? b.band_flag : (b.mode != MS_MODE_OFF);
        if (ms && b.pns_l == b.pns_r) begin
            if (b.pns_l) begin
                rv = quarter_gain(lv, int'(b.sf_r) - int'(b.sf_l), 1'b0);
            end else begin
                rv = clip_coef(longint'(b.left) - longint'(b.right));
                lv = clip_coef(longint'(b.left) + longint'(b.right));
            end
        end
        if (b.cb == CB_IS_OUT_PHASE || b.cb == CB_IS_IN_PHASE) begin
            pos = int'(b.sf_r);
            if (pos < int'(IS_POS_MIN)) pos = int'(IS_POS_MIN);
            if (pos > int'(IS_POS_MAX)) pos = int'(IS_POS_MAX);
            flip = (b.cb == CB_IS_OUT_PHASE);
            if (b.mode == MS_MODE_ALL || (b.mode == MS_MODE_BAND && b.band_flag)) flip = !flip;
            rv = quarter_gain(lv, -pos, flip);
        end
        p.left_out  = lv;
        p.right_out = rv;
        return p;
    endfunction

    function automatic logic [IN_W-1:0] pack_beat(input coef_beat_t b);
        logic [IN_W-1:0] d;
        d = '0;
        d[0 +: CW]       = b.left;
        d[CW +: CW]      = b.right;
        d[2*CW +: 2]     = b.mode;
        d[2*CW+2]        = b.band_flag;
        d[2*CW+3]        = b.pns_l;
        d[2*CW+4]        = b.pns_r;
        d[2*CW+5 +: 4]   = b.cb;
        d[2*CW+9 +: 9]   = b.sf_l;
        d[2*CW+18 +: 9]  = b.sf_r;
        return d;
    endfunction

    function automatic stim_row_t mk_row(
        input logic [CW-1:0] left, input logic [CW-1:0] right, input logic [1:0] mode,
        input logic band_flag, input logic pns_l, input logic pns_r, input logic [3:0] cb,
        input logic signed [8:0] sf_l, input logic signed [8:0] sf_r,
        input bit typed, input logic [CW-1:0] want_l, input logic [CW-1:0] want_r);
        stim_row_t row;
        row.beat.left      = left;
        row.beat.right     = right;
        row.beat.mode      = mode;
        row.beat.band_flag = band_flag;
        row.beat.pns_l     = pns_l;
        row.beat.pns_r     = pns_r;
        row.beat.cb        = cb;
        row.beat.sf_l      = sf_l;
        row.beat.sf_r      = sf_r;
        row.typed          = typed;
        row.want.left_out  = want_l;
        row.want.right_out = want_r;
        return row;
    endfunction

    // Coefficients spread over the full range, the rails and small magnitudes.
    function automatic logic [CW-1:0] random_coef();
        logic signed [CW-1:0] v;
        case ($urandom_range(7))
            0: v = $urandom;
            1: v = 32'h7FFFFFFF - $urandom_range(255);
            2: v = 32'h80000000 + $urandom_range(255);
            3: begin
                v = $urandom_range(65535);
                if ($urandom_range(1) != 0) v = -v;
            end
            default: v = $signed($urandom) >>> $urandom_range(31);
        endcase
        return v;
    endfunction

    function automatic logic [8:0] random_sf();
        int v;
        case ($urandom_range(5))
            0, 1: v = $urandom_range(511);
            2: begin
                // Around the intensity position clamp.
                v = 124 + $urandom_range(8);
                if ($urandom_range(1) != 0) v = -v;
            end
            default: v = int'($urandom_range(40)) - 20;
        endcase
        return 9'(v);
    endfunction

    function automatic coef_beat_t random_beat();
        coef_beat_t b;
        b.left      = random_coef();
        b.right     = random_coef();
        b.mode      = 2'($urandom_range(3));
        b.band_flag = 1'($urandom_range(1));
        b.pns_l     = 1'($urandom_range(1));
        // Mostly matching noise flags, so that mid/side really takes effect.
        b.pns_r     = ($urandom_range(4) == 0) ? ~b.pns_l : b.pns_l;
        case ($urandom_range(9))
            0, 1, 2: b.cb = CB_IS_OUT_PHASE;
            3, 4, 5: b.cb = CB_IS_IN_PHASE;
            default: b.cb = 4'($urandom_range(15));
        endcase
        b.sf_l = random_sf();
        b.sf_r = random_sf();
        return b;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < 10) $display("%s", msg);
        fail_count++;
    endtask

    // Present one beat, hold it until the block takes it, and record what should come back.
    task automatic send_beat(input coef_beat_t b, input bit typed, input stereo_pair_t want);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pack_beat(b);
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_pairs.push_back(typed ? want : rebuild_pair(b));
        @(negedge i_clk);
    endtask

    // The receiver stalls at random; the rate follows the current phase.
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        stereo_pair_t want;
        stereo_pair_t got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.left_out  = o_m_axis_tdata[0 +: CW];
            got.right_out = o_m_axis_tdata[CW +: CW];
            if (pending_pairs.size() == 0) begin
                note_failure($sformatf("unexpected beat: left %h right %h",
                                       got.left_out, got.right_out));
            end else begin
                want = pending_pairs.pop_front();
                if (got.left_out != want.left_out)
                    note_failure($sformatf("left_out mismatch: expected %h, got %h",
                                           want.left_out, got.left_out));
                if (got.right_out != want.right_out)
                    note_failure($sformatf("right_out mismatch: expected %h, got %h",
                                           want.right_out, got.right_out));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        stereo_pair_t none;
        none = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows. Rows marked typed carry an answer that is plain by inspection;
        // the rest go through the predictor.
        directed_rows.push_back(mk_row(32'h0, 32'h0, MS_MODE_OFF, 0, 0, 0, CB_ZERO,
                                       0, 0, 1, 32'h0, 32'h0));
        directed_rows.push_back(mk_row(32'h7FFFFFFF, 32'h80000000, MS_MODE_OFF, 0, 0, 0,
                                       CB_ZERO, 0, 0, 1, 32'h7FFFFFFF, 32'h80000000));
        // Sum and difference hitting both rails.
        directed_rows.push_back(mk_row(32'h7FFFFFFF, 32'h7FFFFFFF, MS_MODE_ALL, 0, 0, 0,
                                       CB_ZERO, 0, 0, 1, 32'h7FFFFFFF, 32'h0));
        directed_rows.push_back(mk_row(32'h80000000, 32'h7FFFFFFF, MS_MODE_ALL, 0, 0, 0,
                                       CB_ZERO, 0, 0, 1, 32'hFFFFFFFF, 32'h80000000));
        directed_rows.push_back(mk_row(32'h80000000, 32'h80000000, MS_MODE_ALL, 0, 0, 0,
                                       CB_ZERO, 0, 0, 1, 32'h80000000, 32'h0));
        // Noise substitution on one channel only skips mid/side; then band mid/side off and on, and no-flip mode.
        directed_rows.push_back(mk_row(32'd5, 32'd9, MS_MODE_ALL, 0, 1, 0, CB_ZERO,
                                       0, 0, 1, 32'd5, 32'd9));
        directed_rows.push_back(mk_row(32'd5, 32'd9, MS_MODE_BAND, 0, 0, 0, CB_ZERO,
                                       0, 0, 1, 32'd5, 32'd9));
        directed_rows.push_back(mk_row(32'd5, 32'd9, MS_MODE_BAND, 1, 0, 0, CB_ZERO,
                                       0, 0, 1, 32'd14, 32'hFFFFFFFC));
        directed_rows.push_back(mk_row(32'd5, 32'd9, MS_MODE_NO_FLIP, 0, 0, 0, CB_ZERO,
                                       0, 0, 1, 32'd14, 32'hFFFFFFFC));
        // Both channels noise-substituted: right is left times the scalefactor gain.
        directed_rows.push_back(mk_row(32'h10000, 32'h0, MS_MODE_ALL, 0, 1, 1, CB_ZERO,
                                       0, 0, 1, 32'h10000, 32'h10000));
        directed_rows.push_back(mk_row(32'h10000, 32'h0, MS_MODE_ALL, 0, 1, 1, CB_ZERO,
                                       -256, 255, 0, none.left_out, none.right_out));
        directed_rows.push_back(mk_row(32'h80000000, 32'h0, MS_MODE_ALL, 0, 1, 1, CB_ZERO,
                                       255, -256, 0, none.left_out, none.right_out));
        // Intensity stereo, in and out of phase.
        directed_rows.push_back(mk_row(32'h12345, 32'h777, MS_MODE_OFF, 0, 0, 0,
                                       CB_IS_IN_PHASE, 0, 0, 1, 32'h12345, 32'h12345));
        directed_rows.push_back(mk_row(32'h12345, 32'h777, MS_MODE_OFF, 0, 0, 0,
                                       CB_IS_OUT_PHASE, 0, 0, 1, 32'h12345, 32'hFFFEDCBB));
        directed_rows.push_back(mk_row(32'h20000, 32'h0, MS_MODE_OFF, 0, 0, 0,
                                       CB_IS_IN_PHASE, 0, 4, 1, 32'h20000, 32'h10000));
        // Intensity positions at and beyond the clamp, with rail inputs.
        directed_rows.push_back(mk_row(32'h7FFFFFFF, 32'h1, MS_MODE_OFF, 0, 0, 0,
                                       CB_IS_IN_PHASE, 0, -256, 0, none.left_out,
                                       none.right_out));
        directed_rows.push_back(mk_row(32'h80000000, 32'h0, MS_MODE_OFF, 0, 0, 0,
                                       CB_IS_OUT_PHASE, 0, -128, 0, none.left_out,
                                       none.right_out));
        directed_rows.push_back(mk_row(32'h80000000, 32'h0, MS_MODE_OFF, 0, 0, 0,
                                       CB_IS_IN_PHASE, 0, 255, 0, none.left_out,
                                       none.right_out));
        // Mid/side or paired noise ahead of intensity, with and without the extra sign flip, and intensity alone.
        directed_rows.push_back(mk_row(32'h3000, 32'h1000, MS_MODE_ALL, 0, 0, 0,
                                       CB_IS_OUT_PHASE, 0, 3, 0, none.left_out,
                                       none.right_out));
        directed_rows.push_back(mk_row(32'h3000, 32'h1000, MS_MODE_NO_FLIP, 0, 0, 0,
                                       CB_IS_OUT_PHASE, 0, -3, 0, none.left_out,
                                       none.right_out));
        directed_rows.push_back(mk_row(32'h3000, 32'h1000, MS_MODE_BAND, 1, 1, 1,
                                       CB_IS_IN_PHASE, -2, 7, 0, none.left_out,
                                       none.right_out));
        directed_rows.push_back(mk_row(32'hFFFFFFFF, 32'h0, MS_MODE_OFF, 0, 0, 0,
                                       CB_IS_IN_PHASE, 0, 1, 0, none.left_out,
                                       none.right_out));
        directed_rows.push_back(mk_row(32'hFFFFFFFF, 32'hFFFFFFFF, MS_MODE_NO_FLIP, 1, 1, 1,
                                       CB_IS_IN_PHASE, -1, -1, 0, none.left_out,
                                       none.right_out));
        // A codebook next to the intensity ones leaves right alone.
        directed_rows.push_back(mk_row(32'h4444, 32'h5555, MS_MODE_OFF, 0, 0, 0, CB_NOISE,
                                       0, 8, 1, 32'h4444, 32'h5555));

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        // Random beats in three phases: receiver stalling heavily, then sender idling
        // heavily, then full rate on both sides.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS/3) begin
                src_idle_pct  = 70;
                snk_stall_pct = 6;
            end
            if (i == 2*RANDOM_ITEMS/3) begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            send_beat(random_beat(), 1'b0, none);
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_pairs.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_pairs.size()));

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
